/* sv/pee_pkg.sv */
// ----------------------------------------------------------------------------
// pee_pkg
// Types and character codes for the postfix expression evaluator.
// ----------------------------------------------------------------------------
package pee_pkg;

  typedef struct packed {
    logic [7:0] symbol;
    logic       last;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] result;
    logic [1:0]         status;
  } out_item_t;

  localparam logic [1:0] FAULT_NONE      = 2'd0;
  localparam logic [1:0] FAULT_OVERFLOW  = 2'd1;
  localparam logic [1:0] FAULT_UNDERFLOW = 2'd2;
  localparam logic [1:0] FAULT_DIVZERO   = 2'd3;

  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_MUL   = 8'h2A;
  localparam logic [7:0] CH_DIV   = 8'h2F;
  localparam logic [7:0] CH_POW   = 8'h5E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  typedef enum logic [2:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MUL = 3'd2,
    OP_DIV = 3'd3,
    OP_POW = 3'd4
  } op_t;

  // Classified command from the front to the back.
  typedef struct packed {
    logic        push;     // push the number first
    logic [31:0] number;
    logic        do_op;
    op_t         op;
    logic        fin;
  } cmd_t;

endpackage

/* sv/pee_front.sv */
// ----------------------------------------------------------------------------
// pee_front
// Accepts characters, builds digit runs and emits classified commands.
// ----------------------------------------------------------------------------
module pee_front import pee_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_item_t in_data,
  output logic     cmd_valid,
  input  logic     cmd_stall,
  output cmd_t     cmd
);

  logic [31:0] acc;
  logic        in_number;
  logic        is_digit;
  logic [31:0] acc10;
  cmd_t        c;

  assign is_digit = (in_data.symbol >= CH_ZERO) && (in_data.symbol <= CH_NINE);
  assign acc10 = (acc << 3) + (acc << 1) + {24'd0, in_data.symbol - CH_ZERO};

  always_comb begin
    c.push   = in_number && (!is_digit || in_data.last);
    c.number = acc;
    c.do_op  = 1'b0;
    c.op     = OP_ADD;
    c.fin    = in_data.last;
    if (is_digit) begin
      c.number = acc10;
      c.push   = in_data.last;
    end else begin
      case (in_data.symbol)
        CH_PLUS:  begin c.do_op = 1'b1; c.op = OP_ADD; end
        CH_MINUS: begin c.do_op = 1'b1; c.op = OP_SUB; end
        CH_MUL:   begin c.do_op = 1'b1; c.op = OP_MUL; end
        CH_DIV:   begin c.do_op = 1'b1; c.op = OP_DIV; end
        CH_POW:   begin c.do_op = 1'b1; c.op = OP_POW; end
        default:  ;
      endcase
    end
  end

  // digits that neither push nor finish produce no command
  logic need;
  assign need = c.push || c.do_op || c.fin;
  assign in_stall = need && cmd_stall;
  assign cmd_valid = in_valid && need;
  assign cmd = c;

  always_ff @(posedge clk) begin
    if (rst) begin
      acc       <= '0;
      in_number <= 1'b0;
    end else if (in_valid && !in_stall) begin
      if (in_data.last) begin
        acc       <= '0;
        in_number <= 1'b0;
      end else if (is_digit) begin
        acc       <= acc10;
        in_number <= 1'b1;
      end else begin
        acc       <= '0;
        in_number <= 1'b0;
      end
    end
  end

endmodule

/* sv/pee_queue.sv */
// ----------------------------------------------------------------------------
// pee_queue
// Two-entry command queue between front and back.
// ----------------------------------------------------------------------------
module pee_queue import pee_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic wr_valid,
  output logic wr_stall,
  input  cmd_t wr_data,
  output logic rd_valid,
  input  logic rd_stall,
  output cmd_t rd_data
);

  cmd_t       mem [2];
  logic       wp, rp;
  logic [1:0] cnt;
  logic       wr, rd;

  assign wr_stall = (cnt == 2'd2);
  assign rd_valid = (cnt != 2'd0);
  assign rd_data  = mem[rp];
  assign wr = wr_valid && !wr_stall;
  assign rd = rd_valid && !rd_stall;

  always_ff @(posedge clk) begin
    if (wr) mem[wp] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= '0;
    end else begin
      if (wr) wp <= ~wp;
      if (rd) rp <= ~rp;
      cnt <= cnt + {1'b0, wr} - {1'b0, rd};
    end
  end

endmodule

/* sv/pee_back.sv */
// ----------------------------------------------------------------------------
// pee_back
// Executes commands on the value stack; shared iterative mul/div/pow unit.
// ----------------------------------------------------------------------------
module pee_back import pee_pkg::*; #(
  parameter int STACK_DEPTH = 64
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      cmd_valid,
  output logic      cmd_stall,
  input  cmd_t      cmd,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam logic [CW-1:0] FULL = CW'(STACK_DEPTH);

  typedef enum logic [10:0] {
    S_IDLE  = 11'b00000000001,
    S_PUSHN = 11'b00000000010,
    S_POP1  = 11'b00000000100,
    S_POP1W = 11'b00000001000,
    S_POP2  = 11'b00000010000,
    S_POP2W = 11'b00000100000,
    S_CALC  = 11'b00001000000,
    S_ITER  = 11'b00010000000,
    S_PUSHR = 11'b00100000000,
    S_FINP  = 11'b01000000000,
    S_OUT   = 11'b10000000000
  } state_t;

  state_t      state, state_next;
  logic [31:0] mem [STACK_DEPTH];
  logic [31:0] rdata;
  logic [CW-1:0] count;
  logic [1:0]  fault;
  cmd_t        cur;
  logic [31:0] rhs, lhs, res;
  logic [31:0] a, b, acc, rem;
  logic [5:0]  step;
  logic        qneg;
  logic        mem_we;
  logic [AW-1:0] mem_wa, mem_ra;
  logic [31:0] mem_wd;

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    rdata <= mem[mem_ra];
  end

  logic [CW-1:0] cm1;
  assign cm1 = count - CW'(1);
  assign mem_ra = cm1[AW-1:0];

  logic   accept;
  assign  cmd_stall = (state != S_IDLE);
  assign  accept = cmd_valid && (state == S_IDLE);
  // first S_OUT cycle loads the popped value; the beat is offered from the next
  assign  out_valid = (state == S_OUT) && !cur.fin;
  assign  out_data.result = res;
  assign  out_data.status = fault;

  function automatic logic [1:0] raise(input logic [1:0] f, input logic [1:0] code);
    raise = (f == FAULT_NONE) ? code : f;
  endfunction

  logic [32:0] trial;
  assign trial = {rem[31:0], a[31]} - {1'b0, b};

  always_comb begin
    mem_we = 1'b0;
    mem_wa = count[AW-1:0];
    mem_wd = cur.number;
    if (state == S_PUSHN && count != FULL) mem_we = 1'b1;
    if (state == S_PUSHR && count != FULL) begin
      mem_we = 1'b1;
      mem_wd = res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      fault <= FAULT_NONE;
    end else begin
      unique case (state)
        S_IDLE: if (accept) begin
          cur <= cmd;
          if (cmd.push) state <= S_PUSHN;
          else if (cmd.do_op) state <= S_POP1;
          else state <= S_FINP;
        end
        S_PUSHN: begin
          if (count == FULL) fault <= raise(fault, FAULT_OVERFLOW);
          else count <= count + CW'(1);
          state <= cur.do_op ? S_POP1 : (cur.fin ? S_FINP : S_IDLE);
        end
        S_POP1: state <= S_POP1W;
        S_POP1W: begin
          if (count == '0) begin
            rhs <= 32'hFFFF_FFFF;
            fault <= raise(fault, FAULT_UNDERFLOW);
          end else begin
            rhs <= rdata;
            count <= cm1;
          end
          state <= S_POP2;
        end
        S_POP2: state <= S_POP2W;
        S_POP2W: begin
          if (count == '0) begin
            lhs <= 32'hFFFF_FFFF;
            fault <= raise(fault, FAULT_UNDERFLOW);
          end else begin
            lhs <= rdata;
            count <= cm1;
          end
          state <= S_CALC;
        end
        S_CALC: begin
          step  <= '0;
          state <= S_ITER;
          acc   <= 32'd1;
          rem   <= '0;
          unique case (cur.op)
            OP_ADD: begin res <= lhs + rhs; state <= S_PUSHR; end
            OP_SUB: begin res <= lhs - rhs; state <= S_PUSHR; end
            OP_MUL: begin a <= lhs; b <= rhs; acc <= '0; end
            OP_DIV: begin
              if (rhs == '0) begin
                res   <= '0;
                fault <= raise(fault, FAULT_DIVZERO);
                state <= S_PUSHR;
              end else begin
                a    <= lhs[31] ? -lhs : lhs;
                b    <= rhs[31] ? -rhs : rhs;
                qneg <= lhs[31] ^ rhs[31];
              end
            end
            OP_POW: begin
              if (rhs[31]) begin res <= 32'd1; state <= S_PUSHR; end
              else begin a <= lhs; b <= rhs; end
            end
            default: state <= S_PUSHR;
          endcase
        end
        S_ITER: begin
          step <= step + 6'd1;
          unique case (cur.op)
            OP_MUL: begin
              // shift-add, one multiplier bit per cycle
              if (b[0]) acc <= acc + a;
              a <= a << 1;
              b <= b >> 1;
              if (step == 6'd31) begin
                res   <= b[0] ? acc + a : acc;
                state <= S_PUSHR;
              end
            end
            OP_DIV: begin
              // restoring division, quotient bits shift into a
              if (!trial[32]) begin
                rem <= trial[31:0];
                a   <= {a[30:0], 1'b1};
              end else begin
                rem <= {rem[30:0], a[31]};
                a   <= {a[30:0], 1'b0};
              end
              if (step == 6'd31) begin
                res   <= qneg ? -{a[30:0], !trial[32]} : {a[30:0], !trial[32]};
                state <= S_PUSHR;
              end
            end
            default: begin
              // power: 31 square-and-multiply steps using 32x32 multiplies
              if (b[0]) acc <= acc * a;
              a <= a * a;
              b <= b >> 1;
              if (step == 6'd30) begin
                res   <= b[0] ? acc * a : acc;
                state <= S_PUSHR;
              end
            end
          endcase
        end
        S_PUSHR: begin
          if (count == FULL) fault <= raise(fault, FAULT_OVERFLOW);
          else count <= count + CW'(1);
          state <= cur.fin ? S_FINP : S_IDLE;
        end
        S_FINP: state <= S_OUT;
        S_OUT: begin
          if (count == '0) begin
            res <= 32'hFFFF_FFFF;
            fault <= raise(fault, FAULT_UNDERFLOW);
          end else begin
            res <= rdata;
          end
          state <= S_OUT;
          cur.fin <= 1'b0;
          if (!cur.fin && !out_stall) begin
            state <= S_IDLE;
            count <= '0;
            fault <= FAULT_NONE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* sv/postfix_expression_evaluator_core.sv */
// ----------------------------------------------------------------------------
// postfix_expression_evaluator_core
// Postfix evaluator: character front end, command queue, stack engine.
// ----------------------------------------------------------------------------
// The stack engine takes + and - through two pops, each with a read wait, a calculate state and
// a result push (after a number push when one comes first); *, / and ^ also iterate in the shared
// unit, save a divide by zero or a negative exponent. The final character passes a final pop state
// and an output state before the result beat. One item in flight in the stack engine; the queue
// holds two commands. Synchronous reset clears stack count, accumulator and fault status.
module postfix_expression_evaluator_core import pee_pkg::*; #(
  parameter int STACK_DEPTH = 64
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  logic f_valid, f_stall, b_valid, b_stall;
  cmd_t f_cmd, b_cmd;

  pee_front u_front (
    .clk, .rst, .in_valid, .in_stall, .in_data,
    .cmd_valid(f_valid), .cmd_stall(f_stall), .cmd(f_cmd)
  );

  pee_queue u_queue (
    .clk, .rst, .wr_valid(f_valid), .wr_stall(f_stall), .wr_data(f_cmd),
    .rd_valid(b_valid), .rd_stall(b_stall), .rd_data(b_cmd)
  );

  pee_back #(.STACK_DEPTH(STACK_DEPTH)) u_back (
    .clk, .rst, .cmd_valid(b_valid), .cmd_stall(b_stall), .cmd(b_cmd),
    .out_valid, .out_stall, .out_data
  );

endmodule
